// ----- hw/rtl/mtc_pkg.sv -----
`timescale 1ns / 1ps
package mtc_pkg;

  // Input and result items
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_line;
  } mtc_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_of_run;
  } mtc_out_t;

  // Work handed from the front to the back
  typedef struct packed {
    logic       is_dec;   // decode result (letter, maybe '?') vs. encode run
    logic       space;    // encode: leading space
    logic [2:0] len;      // encode: number of symbols
    logic [3:0] bits;     // encode: symbols, first one most significant, dash 1
    logic [7:0] letter;   // decode: first result character
    logic       second;   // decode: a trailing '?' follows
  } mtc_job_t;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QUERY = 8'h3F;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_FOLD  = 8'h20;

  localparam int unsigned MAX_SYMBOLS = 4;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam int unsigned ADDR_W = 3;
  localparam logic [0:0] REG_DIRECTION = 1'b0;

  // Marker-prefixed code to letter, zero where no letter exists
  function automatic logic [7:0] code_to_letter(input logic [4:0] idx);
    logic [7:0] l;
    case (idx)
      5'd2:  l = "E";  5'd3:  l = "T";  5'd4:  l = "I";  5'd5:  l = "A";
      5'd6:  l = "N";  5'd7:  l = "M";  5'd8:  l = "S";  5'd9:  l = "U";
      5'd10: l = "R";  5'd11: l = "W";  5'd12: l = "D";  5'd13: l = "K";
      5'd14: l = "G";  5'd15: l = "O";  5'd16: l = "H";  5'd17: l = "V";
      5'd18: l = "F";  5'd20: l = "L";  5'd22: l = "P";  5'd23: l = "J";
      5'd24: l = "B";  5'd25: l = "X";  5'd26: l = "C";  5'd27: l = "Y";
      5'd28: l = "Z";  5'd29: l = "Q";
      default: l = 8'd0;
    endcase
    return l;
  endfunction

  // Letter index A..Z to marker-prefixed code
  function automatic logic [4:0] letter_to_code(input logic [4:0] idx);
    logic [4:0] c;
    case (idx)
      5'd0:  c = 5'd5;   5'd1:  c = 5'd24;  5'd2:  c = 5'd26;  5'd3:  c = 5'd12;
      5'd4:  c = 5'd2;   5'd5:  c = 5'd18;  5'd6:  c = 5'd14;  5'd7:  c = 5'd16;
      5'd8:  c = 5'd4;   5'd9:  c = 5'd23;  5'd10: c = 5'd13;  5'd11: c = 5'd20;
      5'd12: c = 5'd7;   5'd13: c = 5'd6;   5'd14: c = 5'd15;  5'd15: c = 5'd22;
      5'd16: c = 5'd29;  5'd17: c = 5'd10;  5'd18: c = 5'd8;   5'd19: c = 5'd3;
      5'd20: c = 5'd9;   5'd21: c = 5'd17;  5'd22: c = 5'd11;  5'd23: c = 5'd25;
      5'd24: c = 5'd27;  5'd25: c = 5'd28;
      default: c = 5'd0;
    endcase
    return c;
  endfunction

  // Look a collected code up; '?' for empty, overlong or unknown
  function automatic logic [7:0] decode_code(input logic [2:0] len, input logic [3:0] bits);
    logic [4:0] idx;
    logic [7:0] l;
    idx = {1'b0, bits};
    case (len)
      3'd1:    idx = idx | 5'd2;
      3'd2:    idx = idx | 5'd4;
      3'd3:    idx = idx | 5'd8;
      3'd4:    idx = idx | 5'd16;
      default: idx = idx;
    endcase
    l = code_to_letter(idx);
    if (len == 3'd0 || len > 3'(MAX_SYMBOLS) || l == 8'd0) begin
      l = CHAR_QUERY;
    end
    return l;
  endfunction

endpackage

// ----- hw/rtl/mtc_front.sv -----
`timescale 1ns / 1ps
module mtc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              direction_i,
  input  logic              accept_i,
  input  mtc_pkg::mtc_in_t  item_i,
  output logic              job_valid_o,
  output mtc_pkg::mtc_job_t job_o
);

  logic [3:0] code_bits_q, code_bits_d;
  logic [2:0] code_len_q, code_len_d;
  logic       emitted_q, emitted_d;

  logic [7:0] up_char;
  logic       is_letter;
  logic [4:0] enc_code;
  logic [2:0] enc_len;
  logic       is_sym, is_space, eol;
  logic [3:0] sym_bits;
  logic [2:0] sym_len;

  // Classify the character
  always_comb begin
    up_char = item_i.char_in;
    if (item_i.char_in >= mtc_pkg::CHAR_LO_A && item_i.char_in <= mtc_pkg::CHAR_LO_Z) begin
      up_char = item_i.char_in - mtc_pkg::CASE_FOLD;
    end
    is_letter = (up_char >= mtc_pkg::CHAR_UP_A) && (up_char <= mtc_pkg::CHAR_UP_Z);
    enc_code  = mtc_pkg::letter_to_code(5'(up_char - mtc_pkg::CHAR_UP_A));
    if (enc_code[4]) begin
      enc_len = 3'd4;
    end else if (enc_code[3]) begin
      enc_len = 3'd3;
    end else if (enc_code[2]) begin
      enc_len = 3'd2;
    end else begin
      enc_len = 3'd1;
    end
    is_sym   = (item_i.char_in == mtc_pkg::CHAR_DOT) || (item_i.char_in == mtc_pkg::CHAR_DASH);
    is_space = (item_i.char_in == mtc_pkg::CHAR_SPACE);
    eol      = item_i.end_of_line;
  end

  // Collect a dot or dash; freeze the bits once the code is overlong
  always_comb begin
    sym_bits = code_bits_q;
    sym_len  = code_len_q;
    if (is_sym) begin
      if (code_len_q < 3'(mtc_pkg::MAX_SYMBOLS)) begin
        sym_bits = {code_bits_q[2:0], item_i.char_in == mtc_pkg::CHAR_DASH};
        sym_len  = code_len_q + 3'd1;
      end else begin
        sym_len = 3'(mtc_pkg::MAX_SYMBOLS + 1);
      end
    end
  end

  // Build the job and the next state
  always_comb begin
    job_o        = '0;
    job_valid_o  = 1'b0;
    code_bits_d  = code_bits_q;
    code_len_d   = code_len_q;
    emitted_d    = emitted_q;
    if (direction_i == mtc_pkg::DIR_ENCODE) begin
      job_o.is_dec = 1'b0;
      job_o.space  = emitted_q;
      job_o.len    = enc_len;
      job_o.bits   = enc_code[3:0];
      job_valid_o  = is_letter;
      if (is_letter) begin
        emitted_d = 1'b1;
      end
    end else begin
      job_o.is_dec = 1'b1;
      job_o.letter = mtc_pkg::decode_code(sym_len, sym_bits);
      job_o.second = is_space && eol;
      job_valid_o  = is_space || eol;
      code_bits_d  = is_space ? 4'd0 : sym_bits;
      code_len_d   = is_space ? 3'd0 : sym_len;
    end
    if (eol) begin
      code_bits_d = '0;
      code_len_d  = '0;
      emitted_d   = 1'b0;
    end
    job_valid_o = job_valid_o && accept_i;
  end

  // Advance the line state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q <= '0;
      code_len_q  <= '0;
      emitted_q   <= 1'b0;
    end else if (accept_i) begin
      code_bits_q <= code_bits_d;
      code_len_q  <= code_len_d;
      emitted_q   <= emitted_d;
    end
  end

endmodule

// ----- hw/rtl/mtc_job_fifo.sv -----
`timescale 1ns / 1ps
module mtc_job_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mtc_pkg::mtc_job_t data_i,
  output logic              full_o,
  output logic              valid_o,
  output mtc_pkg::mtc_job_t data_o,
  input  logic              pop_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mtc_pkg::mtc_job_t  mem_q [DEPTH];
  logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]      count_q;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  ap_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("job pushed into a full queue");
  ap_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("job popped from an empty queue");
  ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("queue fill count out of range");

endmodule

// ----- hw/rtl/mtc_back.sv -----
`timescale 1ns / 1ps
module mtc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  mtc_pkg::mtc_job_t job_i,
  output logic              job_pop_o,
  output logic              out_valid_o,
  output mtc_pkg::mtc_out_t out_o,
  input  logic              out_pop_i
);

  logic [2:0]        idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  mtc_pkg::mtc_out_t out_q;
  logic [2:0]        job_count;
  logic [2:0]        sym_idx, bit_pos;
  logic [7:0]        next_char;
  logic              is_last, out_ready, emit;

  // Pick the character at the current position of the job
  always_comb begin
    if (job_i.is_dec) begin
      job_count = job_i.second ? 3'd2 : 3'd1;
      next_char = (idx_q == 3'd0) ? job_i.letter : mtc_pkg::CHAR_QUERY;
      sym_idx   = '0;
      bit_pos   = '0;
    end else begin
      job_count = job_i.len + {2'b00, job_i.space};
      sym_idx   = idx_q - {2'b00, job_i.space};
      bit_pos   = job_i.len - 3'd1 - sym_idx;
      if (job_i.space && idx_q == 3'd0) begin
        next_char = mtc_pkg::CHAR_SPACE;
      end else begin
        next_char = job_i.bits[bit_pos[1:0]] ? mtc_pkg::CHAR_DASH : mtc_pkg::CHAR_DOT;
      end
    end
    is_last   = (idx_q == job_count - 3'd1);
    out_ready = !out_valid_q || out_pop_i;
    emit      = job_valid_i && out_ready;
    job_pop_o = emit && is_last;
    idx_d     = emit ? (is_last ? 3'd0 : idx_q + 3'd1) : idx_q;
    out_valid_d = emit || (out_valid_q && !out_pop_i);
  end

  // Hold the result register until popped; one character per cycle while it is free or popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.char_out    <= next_char;
      out_q.last_of_run <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  ap_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> idx_q < job_count) else $error("character index past job end");
  ap_mid_job_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 3'd0 |-> job_valid_i) else $error("job left the queue mid-run");

endmodule

// ----- hw/rtl/morse_text_codec_core.sv -----
`timescale 1ns / 1ps
// The first result of an item passes through the job queue and the result register to the
// result ports. The back end gives one result per cycle while the result register is free
// or popped; an encoded letter gives up to 5 results with its leading space; silent items
// never enter the job queue. The input side accepts one item per cycle while the queue has
// room. Reset (rst_ni low, asynchronous) clears line state, queue, result valid, direction.
module morse_text_codec_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  mtc_pkg::mtc_in_t              in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output mtc_pkg::mtc_out_t             out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtc_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic              direction_q;
  logic              accept;
  logic              job_valid, fifo_full, head_valid, head_pop, out_valid;
  mtc_pkg::mtc_job_t job, head_job;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mtc_pkg::REG_DIRECTION) ? {31'd0, direction_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= mtc_pkg::DIR_ENCODE;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == mtc_pkg::REG_DIRECTION) begin
      direction_q <= pwdata[0];
    end
  end

  assign full   = fifo_full;
  assign accept = push && !fifo_full;
  assign empty  = !out_valid;

  mtc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .direction_i (direction_q),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  mtc_job_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .data_i  (job),
    .full_o  (fifo_full),
    .valid_o (head_valid),
    .data_o  (head_job),
    .pop_i   (head_pop)
  );

  mtc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .job_pop_o   (head_pop),
    .out_valid_o (out_valid),
    .out_o       (out_item_o),
    .out_pop_i   (pop)
  );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

// Predicts the codec output in both modes and checks every result against it
class morse_line_checker;
  string             morse_of[26];
  mtc_pkg::mtc_out_t expected_chars[$];
  logic              direction;
  logic [3:0]        sym_bits;
  logic [2:0]        sym_count;
  logic              letter_seen;
  int                errors;
  int                n_items;
  int                n_results;

  function new();
    morse_of = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
                 "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
                 "..-", "...-", ".--", "-..-", "-.--", "--.."};
    direction   = mtc_pkg::DIR_ENCODE;
    sym_bits    = '0;
    sym_count   = '0;
    letter_seen = 1'b0;
    errors      = 0;
    n_items     = 0;
    n_results   = 0;
  endfunction

  function void set_direction(logic dir);
    direction = dir;
  endfunction

  function int pending();
    return expected_chars.size();
  endfunction

  // Look up the collected symbols, emit a letter or a query mark, clear the code
  function void resolve_code(ref logic [7:0] run[$]);
    string      pat;
    logic [7:0] ch;
    pat = "";
    ch  = mtc_pkg::CHAR_QUERY;
    if (sym_count >= 3'd1 && sym_count <= 3'(mtc_pkg::MAX_SYMBOLS)) begin
      for (int i = int'(sym_count) - 1; i >= 0; i--) pat = {pat, sym_bits[i] ? "-" : "."};
      for (int k = 0; k < 26; k++) begin
        if (morse_of[k] == pat) ch = mtc_pkg::CHAR_UP_A + 8'(k);
      end
    end
    run.push_back(ch);
    sym_bits  = '0;
    sym_count = '0;
  endfunction

  // Work out the results of one accepted item and queue them
  function void note_item(mtc_pkg::mtc_in_t item);
    logic [7:0]        run[$];
    logic [7:0]        up;
    string             pat;
    mtc_pkg::mtc_out_t res;
    n_items++;
    if (direction == mtc_pkg::DIR_ENCODE) begin
      up = item.char_in;
      if (up >= mtc_pkg::CHAR_LO_A && up <= mtc_pkg::CHAR_LO_Z) up = up - mtc_pkg::CASE_FOLD;
      if (up >= mtc_pkg::CHAR_UP_A && up <= mtc_pkg::CHAR_UP_Z) begin
        pat = morse_of[up - mtc_pkg::CHAR_UP_A];
        if (letter_seen) run.push_back(mtc_pkg::CHAR_SPACE);
        for (int i = 0; i < pat.len(); i++) run.push_back(8'(pat[i]));
        letter_seen = 1'b1;
      end
    end else begin
      if (item.char_in == mtc_pkg::CHAR_DOT || item.char_in == mtc_pkg::CHAR_DASH) begin
        if (sym_count < 3'(mtc_pkg::MAX_SYMBOLS)) begin
          sym_bits  = {sym_bits[2:0], item.char_in == mtc_pkg::CHAR_DASH};
          sym_count = sym_count + 3'd1;
        end else begin
          sym_count = 3'(mtc_pkg::MAX_SYMBOLS + 1);
        end
      end else if (item.char_in == mtc_pkg::CHAR_SPACE) begin
        resolve_code(run);
      end
      if (item.end_of_line) resolve_code(run);
    end
    // End of line drops all line state
    if (item.end_of_line) begin
      sym_bits    = '0;
      sym_count   = '0;
      letter_seen = 1'b0;
    end
    for (int i = 0; i < run.size() && i < 5; i++) begin
      res.char_out    = run[i];
      res.last_of_run = (i == run.size() - 1 || i == 4);
      expected_chars.push_back(res);
    end
  endfunction

  // Compare one accepted result with the oldest expectation
  function void check_result(mtc_pkg::mtc_out_t got);
    mtc_pkg::mtc_out_t want;
    n_results++;
    if (expected_chars.size() == 0) begin
      $display("%0t: unexpected result char_out=%h last_of_run=%b", $time,
               got.char_out, got.last_of_run);
      errors++;
      return;
    end
    want = expected_chars.pop_front();
    if (got.char_out !== want.char_out) begin
      $display("%0t: char_out expected %h actual %h", $time, want.char_out, got.char_out);
      errors++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $display("%0t: last_of_run expected %b actual %b", $time, want.last_of_run,
               got.last_of_run);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int unsigned   AW           = mtc_pkg::ADDR_W;
  localparam int            HOLD_CYCLES  = 250;
  localparam int            SETTLE       = 20;
  localparam int            STALL_LIMIT  = 2000;
  localparam int            RAND_PHASES  = 8;
  localparam logic [AW-1:0] ADDR_DIR     = AW'(mtc_pkg::REG_DIRECTION) << 2;
  localparam logic [AW-1:0] ADDR_UNUSED  = AW'(4);

  logic              clk;
  logic              rst_ni    = 1'b0;
  logic              push      = 1'b0;
  logic              full;
  mtc_pkg::mtc_in_t  in_item_i = '0;
  logic              empty;
  logic              pop       = 1'b0;
  mtc_pkg::mtc_out_t out_item_o;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [AW-1:0]     paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  bit                in_idle;
  bit                out_idle;
  bit                hold_request;
  int                stall_count;
  int                useful;
  logic              cur_dir;
  mtc_pkg::mtc_in_t  stim_q[$];
  morse_line_checker lines;

  morse_text_codec_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor both handshakes and watch for a stuck run
  always @(posedge clk) begin
    if (rst_ni) begin
      if (pop && !empty) lines.check_result(out_item_o);
      if (push && !full) lines.note_item(in_item_i);
      if ((pop && !empty) || (push && !full)) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
      if (stall_count >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Receiver: pop with random stall bursts and one long hold-off
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (out_idle && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Offer one item and hold it until accepted; starts and ends at a falling edge
  task automatic send_item(input mtc_pkg::mtc_in_t item);
    if (in_idle && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    push      <= 1'b1;
    in_item_i <= item;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic send_all();
    while (stim_q.size() != 0) send_item(stim_q.pop_front());
    push <= 1'b0;
  endtask

  // Let every expected result out, then let queued silent items settle
  task automatic drain();
    while (lines.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic apb_write(input logic [AW-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_DIR) lines.set_direction(data[0]);
  endtask

  // Read direction back and compare with the expected setting
  task automatic check_direction();
    logic [31:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_DIR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {31'b0, lines.direction}) begin
      $display("%0t: direction read expected %h actual %h", $time,
               {31'b0, lines.direction}, got);
      lines.errors++;
    end
  endtask

  task automatic add_item(input logic [7:0] ch, input logic eol);
    mtc_pkg::mtc_in_t item;
    item.char_in     = ch;
    item.end_of_line = eol;
    stim_q.push_back(item);
  endtask

  function automatic logic [7:0] any_letter();
    logic [7:0] ch;
    ch = mtc_pkg::CHAR_UP_A + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 1) == 1) ch = ch + mtc_pkg::CASE_FOLD;
    return ch;
  endfunction

  // Encode text: mostly letters, some noise bytes, lines of random length
  task automatic build_encode(input int target);
    useful = 0;
    while (useful < target) begin
      if ($urandom_range(0, 9) == 0) begin
        add_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
        add_item(any_letter(), $urandom_range(0, 7) == 0);
        useful++;
      end
    end
  endtask

  // Decode text: words of letter codes, some bad codes and noise, random line ends
  task automatic build_decode(input int target);
    string pat;
    int    pick;
    useful = 0;
    while (useful < target) begin
      pick = $urandom_range(0, 9);
      pat  = "";
      if (pick < 7) begin
        pat = lines.morse_of[$urandom_range(0, 25)];
      end else if (pick < 9) begin
        repeat ($urandom_range(1, 6)) pat = {pat, $urandom_range(0, 1) ? "-" : "."};
      end
      for (int i = 0; i < pat.len(); i++) begin
        if ($urandom_range(0, 9) == 0) add_item(8'($urandom_range(0, 255)), 1'b0);
        add_item(8'(pat[i]), 1'b0);
        useful++;
      end
      pick = $urandom_range(0, 5);
      if (pick == 0 && pat.len() != 0) begin
        stim_q[stim_q.size() - 1].end_of_line = 1'b1;
      end else begin
        add_item(mtc_pkg::CHAR_SPACE, pick <= 1);
        useful++;
      end
    end
  endtask

  initial begin
    lines = new();
    cur_dir = mtc_pkg::DIR_ENCODE;
    repeat (10) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);
    check_direction();

    // Directed encode: case fold, letter range edges, longest run, silent line end
    add_item(mtc_pkg::CHAR_UP_A, 1'b0);
    add_item(mtc_pkg::CHAR_LO_Z, 1'b0);
    add_item(mtc_pkg::CHAR_UP_A - 8'd1, 1'b0);
    add_item(mtc_pkg::CHAR_UP_Z + 8'd1, 1'b0);
    add_item(mtc_pkg::CHAR_LO_A - 8'd1, 1'b0);
    add_item(mtc_pkg::CHAR_LO_Z + 8'd1, 1'b0);
    add_item(mtc_pkg::CHAR_UP_A + 8'd16, 1'b0);
    add_item(8'hFF, 1'b1);
    send_all();
    drain();

    apb_write(ADDR_DIR, 32'hFFFF_FFFF);
    check_direction();

    // Directed decode: good code, overlong code at line end, unknown code,
    // space at line end, ignored byte, then a code left open across a mode change
    add_item(mtc_pkg::CHAR_DOT, 1'b0);
    add_item(mtc_pkg::CHAR_DASH, 1'b0);
    add_item(mtc_pkg::CHAR_SPACE, 1'b0);
    repeat (4) add_item(mtc_pkg::CHAR_DOT, 1'b0);
    add_item(mtc_pkg::CHAR_DOT, 1'b1);
    add_item(mtc_pkg::CHAR_DOT, 1'b0);
    add_item(mtc_pkg::CHAR_DOT, 1'b0);
    add_item(mtc_pkg::CHAR_DASH, 1'b0);
    add_item(mtc_pkg::CHAR_DASH, 1'b0);
    add_item(mtc_pkg::CHAR_SPACE, 1'b0);
    add_item(mtc_pkg::CHAR_SPACE, 1'b1);
    add_item("x", 1'b0);
    add_item(mtc_pkg::CHAR_DOT, 1'b0);
    add_item(mtc_pkg::CHAR_DASH, 1'b0);
    send_all();
    drain();

    apb_write(ADDR_DIR, 32'hFFFF_FFFE);
    apb_write(ADDR_UNUSED, 32'h0000_0001);
    check_direction();

    // Random phases alternate the mode; lines often run across the switch
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < RAND_PHASES - 2) begin
        in_idle  = $urandom_range(0, 3) != 0;
        out_idle = $urandom_range(0, 3) != 0;
      end else begin
        in_idle  = 1'b0;
        out_idle = 1'b0;
      end
      if (p == 0) hold_request = 1'b1;
      if (cur_dir == mtc_pkg::DIR_ENCODE) begin
        build_encode($urandom_range(45, 60));
      end else begin
        build_decode($urandom_range(45, 60));
      end
      send_all();
      drain();
      cur_dir = ~cur_dir;
      apb_write(ADDR_DIR, {$urandom} & 32'hFFFF_FFFE | {31'b0, cur_dir});
      check_direction();
    end

    $display("Covered %0d items and %0d results in both modes over %0d random phases,",
             lines.n_items, lines.n_results, RAND_PHASES);
    $display("with a long receiver hold-off and mode switches inside open lines.");
    if (lines.errors == 0 && lines.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
